[rtl/cgr_pkg.sv]
// Shared types, constants and sizes of the chaos-game k-mer histogram core.
// Used by every module of the block but cgr_ram; depends on nothing.
package cgr_pkg;

   localparam int MAX_K = 8;
   localparam int COUNT_WIDTH = 32;

   localparam int COORD_WIDTH = MAX_K;
   localparam int ADDR_WIDTH = 2 * MAX_K;
   localparam int TABLE_DEPTH = 1 << ADDR_WIDTH;
   localparam int K_WIDTH = $clog2(MAX_K + 1);
   localparam int WIN_IDX_WIDTH = (MAX_K > 1) ? $clog2(MAX_K) : 1;
   localparam int SUM_WIDTH = $clog2(MAX_K * 255 + 1);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH = 8;

   localparam logic CMD_FEED = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam logic [7:0] CHAR_A = 8'd65;
   localparam logic [7:0] CHAR_C = 8'd67;
   localparam logic [7:0] CHAR_G = 8'd71;
   localparam logic [7:0] CHAR_T = 8'd84;
   localparam logic [7:0] CHAR_N = 8'd78;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_KMER_LEN = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_QUAL_OFFSET = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ONLY_VALID = 2'd2;

   localparam logic [3:0] KMER_LEN_RESET = 4'd4;
   localparam logic [7:0] QUAL_OFFSET_RESET = 8'd33;

   typedef logic [COORD_WIDTH-1:0] coord_type;
   typedef logic [ADDR_WIDTH-1:0] addr_type;
   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef logic [K_WIDTH-1:0] k_type;
   typedef logic [SUM_WIDTH-1:0] sum_type;

   typedef struct packed {
      logic       cmd;
      logic [7:0] base_char;
      logic [7:0] quality_char;
      logic       read_valid;
      logic       read_end;
      logic [7:0] addr_x;
      logic [7:0] addr_y;
   } cgr_req_type;

   typedef struct packed {
      logic        word_done;
      logic [7:0]  cell_x;
      logic [7:0]  cell_y;
      logic [31:0] cell_count;
      logic [31:0] cell_quality;
      logic [31:0] total_words;
   } cgr_rsp_type;

   typedef struct packed {
      logic                       valid;
      logic [CSR_INDEX_WIDTH-1:0] index;
      logic [CSR_DATA_WIDTH-1:0]  data;
   } cgr_csr_wr_type;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_READ,
      OP_UPDATE
   } cgr_op_kind_type;

   typedef struct packed {
      cgr_op_kind_type kind;
      coord_type       addr_x;
      coord_type       addr_y;
      count_type       excess;
   } cgr_op_type;

   typedef struct packed {
      logic empty;
      logic full;
   } cgr_queue_status_type;

   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_WAIT
   } cgr_back_state_type;

endpackage

[rtl/cgr_kmer_histogram_core.sv]
// Top level of the chaos-game k-mer histogram core.
// Depends on cgr_pkg, cgr_front, cgr_queue and cgr_back.
//
// After reset the block sweeps both 65536-entry tables to zero, one entry a cycle, and holds
// busy high for the whole sweep; configuration writes are taken throughout. A transaction
// is accepted when start is high and busy is low. The front end classifies it in the cycle it
// is accepted and places one operation in a four-entry queue, so it keeps accepting while the
// back end works; outside the sweep, busy rises only when that queue is full. The back end
// answers a base that completes no word from its idle state and takes a table read or
// a word update through its idle and wait states, a read-modify-write through the tables'
// registered read port. Each result appears for a single cycle with rsp_valid, always in order;
// the receiver cannot stall it, so it must take every result as it comes. The user must write
// configuration only while the block is idle; the block itself does not enforce it.
module cgr_kmer_histogram_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  cgr_pkg::cgr_req_type                 req_data,
   output logic                                 rsp_valid,
   output cgr_pkg::cgr_rsp_type                 rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [cgr_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [cgr_pkg::CSR_DATA_WIDTH-1:0]   csr_data
);

   logic                          accept;
   logic                          pop;
   logic                          clearing;
   cgr_pkg::cgr_op_type           front_op;
   cgr_pkg::cgr_op_type           head_op;
   cgr_pkg::cgr_queue_status_type q_status;
   cgr_pkg::cgr_csr_wr_type       csr_wr;

   assign busy = q_status.full || clearing;
   assign accept = start && !busy;
   assign csr_ready = 1'b1;

   always_comb begin
      csr_wr.valid = csr_valid && csr_ready;
      csr_wr.index = csr_index;
      csr_wr.data = csr_data;
   end

   cgr_front u_front (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .req(req_data),
      .csr_wr(csr_wr),
      .op(front_op)
   );

   cgr_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(accept),
      .push_op(front_op),
      .pop(pop),
      .head_op(head_op),
      .status(q_status)
   );

   cgr_back u_back (
      .clock(clock),
      .reset(reset),
      .head_op(head_op),
      .head_valid(!q_status.empty),
      .pop(pop),
      .clearing(clearing),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data)
   );

endmodule

[rtl/cgr_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module cgr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[rtl/cgr_front.sv]
// Front end: configuration registers, base decoding, coordinate and quality window state.
// Turns each accepted transaction into a table operation. Depends on cgr_pkg.
module cgr_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  cgr_pkg::cgr_req_type    req,
   input  cgr_pkg::cgr_csr_wr_type csr_wr,
   output cgr_pkg::cgr_op_type     op
);

   logic [3:0]          kmer_len_ff, kmer_len_in;
   logic [7:0]          qual_offset_ff, qual_offset_in;
   logic                only_valid_ff, only_valid_in;
   cgr_pkg::coord_type  x_ff, x_in;
   cgr_pkg::coord_type  y_ff, y_in;
   cgr_pkg::k_type      run_ff, run_in;
   cgr_pkg::sum_type    sum_ff, sum_in;
   logic [7:0]          win_ff [cgr_pkg::MAX_K];
   logic [7:0]          win_in [cgr_pkg::MAX_K];

   logic                        is_base;
   logic                        is_n;
   logic                        bx;
   logic                        by;
   logic                        skip;
   logic                        word;
   cgr_pkg::k_type              k;
   cgr_pkg::k_type              run_inc;
   cgr_pkg::k_type              shamt;
   cgr_pkg::coord_type          x_shift;
   cgr_pkg::coord_type          y_shift;
   cgr_pkg::sum_type            sum_add;
   cgr_pkg::sum_type            sum_word;
   cgr_pkg::count_type          bq_k;
   logic [7:0]                  win_shift [cgr_pkg::MAX_K];
   logic [cgr_pkg::WIN_IDX_WIDTH-1:0] old_idx;

   always_comb begin
      if (kmer_len_ff == 4'd0) begin
         k = cgr_pkg::K_WIDTH'(1);
      end else if (int'(kmer_len_ff) > cgr_pkg::MAX_K) begin
         k = cgr_pkg::K_WIDTH'(cgr_pkg::MAX_K);
      end else begin
         k = cgr_pkg::K_WIDTH'(kmer_len_ff);
      end

      is_base = 1'b0;
      is_n = 1'b0;
      bx = 1'b0;
      by = 1'b0;
      case (req.base_char)
         cgr_pkg::CHAR_A: begin
            is_base = 1'b1;
            bx = 1'b1;
         end
         cgr_pkg::CHAR_C: begin
            is_base = 1'b1;
         end
         cgr_pkg::CHAR_G: begin
            is_base = 1'b1;
            by = 1'b1;
         end
         cgr_pkg::CHAR_T: begin
            is_base = 1'b1;
            bx = 1'b1;
            by = 1'b1;
         end
         cgr_pkg::CHAR_N: begin
            is_n = 1'b1;
         end
         default: begin
         end
      endcase

      skip = only_valid_ff && !req.read_valid;

      x_shift = (x_ff >> 1) | (cgr_pkg::COORD_WIDTH'(bx) << (cgr_pkg::MAX_K - 1));
      y_shift = (y_ff >> 1) | (cgr_pkg::COORD_WIDTH'(by) << (cgr_pkg::MAX_K - 1));
      win_shift[0] = req.quality_char;
      for (int i = 1; i < cgr_pkg::MAX_K; i++) begin
         win_shift[i] = win_ff[i-1];
      end
      sum_add = sum_ff + cgr_pkg::SUM_WIDTH'(req.quality_char);
      run_inc = run_ff + cgr_pkg::K_WIDTH'(1);
      word = run_inc >= k;
      shamt = cgr_pkg::K_WIDTH'(cgr_pkg::MAX_K) - k;
      bq_k = cgr_pkg::COUNT_WIDTH'(qual_offset_ff) * cgr_pkg::COUNT_WIDTH'(k);
      old_idx = cgr_pkg::WIN_IDX_WIDTH'(k - cgr_pkg::K_WIDTH'(1));
      sum_word = sum_add - cgr_pkg::SUM_WIDTH'(win_shift[old_idx]);

      kmer_len_in = kmer_len_ff;
      qual_offset_in = qual_offset_ff;
      only_valid_in = only_valid_ff;
      x_in = x_ff;
      y_in = y_ff;
      run_in = run_ff;
      sum_in = sum_ff;
      win_in = win_ff;

      op.kind = cgr_pkg::OP_NONE;
      op.addr_x = '0;
      op.addr_y = '0;
      op.excess = '0;

      if (accept) begin
         if (req.cmd == cgr_pkg::CMD_READ) begin
            op.kind = cgr_pkg::OP_READ;
            op.addr_x = cgr_pkg::COORD_WIDTH'(req.addr_x);
            op.addr_y = cgr_pkg::COORD_WIDTH'(req.addr_y);
         end else begin
            if (!skip) begin
               if (is_base) begin
                  x_in = x_shift;
                  y_in = y_shift;
                  win_in = win_shift;
                  sum_in = sum_add;
                  run_in = run_inc;
                  if (word) begin
                     op.kind = cgr_pkg::OP_UPDATE;
                     op.addr_x = x_shift >> shamt;
                     op.addr_y = y_shift >> shamt;
                     op.excess = cgr_pkg::COUNT_WIDTH'(sum_add) - bq_k;
                     sum_in = sum_word;
                     run_in = k - cgr_pkg::K_WIDTH'(1);
                  end
               end else if (is_n) begin
                  run_in = '0;
                  sum_in = '0;
               end
            end
            if (req.read_end) begin
               run_in = '0;
               sum_in = '0;
            end
         end
      end

      if (csr_wr.valid) begin
         case (csr_wr.index)
            cgr_pkg::REG_KMER_LEN: begin
               kmer_len_in = csr_wr.data[3:0];
               run_in = '0;
               sum_in = '0;
            end
            cgr_pkg::REG_QUAL_OFFSET: begin
               qual_offset_in = csr_wr.data[7:0];
            end
            cgr_pkg::REG_ONLY_VALID: begin
               only_valid_in = csr_wr.data[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kmer_len_ff <= cgr_pkg::KMER_LEN_RESET;
         qual_offset_ff <= cgr_pkg::QUAL_OFFSET_RESET;
         only_valid_ff <= 1'b0;
         x_ff <= '0;
         y_ff <= '0;
         run_ff <= '0;
         sum_ff <= '0;
      end else begin
         kmer_len_ff <= kmer_len_in;
         qual_offset_ff <= qual_offset_in;
         only_valid_ff <= only_valid_in;
         x_ff <= x_in;
         y_ff <= y_in;
         run_ff <= run_in;
         sum_ff <= sum_in;
      end
      win_ff <= win_in;
   end

endmodule

[rtl/cgr_queue.sv]
// Short queue of table operations between the front end and the back end.
// Depends on cgr_pkg.
module cgr_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  cgr_pkg::cgr_op_type           push_op,
   input  logic                          pop,
   output cgr_pkg::cgr_op_type           head_op,
   output cgr_pkg::cgr_queue_status_type status
);

   cgr_pkg::cgr_op_type            entries_ff [cgr_pkg::QUEUE_DEPTH];
   logic [cgr_pkg::QPTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [cgr_pkg::QPTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [cgr_pkg::QCNT_WIDTH-1:0] count_ff, count_in;

   localparam logic [cgr_pkg::QPTR_WIDTH-1:0] LAST_PTR =
      cgr_pkg::QPTR_WIDTH'(cgr_pkg::QUEUE_DEPTH - 1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
      head_op = entries_ff[rd_ptr_ff];
      status.empty = (count_ff == '0);
      status.full = (count_ff == cgr_pkg::QCNT_WIDTH'(cgr_pkg::QUEUE_DEPTH));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

[rtl/cgr_back.sv]
// Back end: clearing pass, read-modify-write of the count and quality tables, result register.
// Depends on cgr_pkg and cgr_ram.
module cgr_back (
   input  logic                 clock,
   input  logic                 reset,
   input  cgr_pkg::cgr_op_type  head_op,
   input  logic                 head_valid,
   output logic                 pop,
   output logic                 clearing,
   output logic                 rsp_valid,
   output cgr_pkg::cgr_rsp_type rsp_data
);

   cgr_pkg::cgr_back_state_type state_ff, state_in;
   cgr_pkg::addr_type           clr_ff, clr_in;
   cgr_pkg::cgr_op_type         op_ff, op_in;
   cgr_pkg::count_type          total_ff, total_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   cgr_pkg::cgr_rsp_type        rsp_ff, rsp_in;

   logic               we;
   cgr_pkg::addr_type  waddr;
   cgr_pkg::addr_type  raddr;
   cgr_pkg::count_type cnt_wdata;
   cgr_pkg::count_type qual_wdata;
   cgr_pkg::count_type cnt_rdata;
   cgr_pkg::count_type qual_rdata;

   cgr_ram #(
      .WIDTH(cgr_pkg::COUNT_WIDTH),
      .DEPTH(cgr_pkg::TABLE_DEPTH)
   ) u_count_ram (
      .clock(clock),
      .we(we),
      .waddr(waddr),
      .wdata(cnt_wdata),
      .raddr(raddr),
      .rdata(cnt_rdata)
   );

   cgr_ram #(
      .WIDTH(cgr_pkg::COUNT_WIDTH),
      .DEPTH(cgr_pkg::TABLE_DEPTH)
   ) u_quality_ram (
      .clock(clock),
      .we(we),
      .waddr(waddr),
      .wdata(qual_wdata),
      .raddr(raddr),
      .rdata(qual_rdata)
   );

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      op_in = op_ff;
      total_in = total_ff;
      rsp_valid_in = 1'b0;
      rsp_in = '0;
      pop = 1'b0;
      we = 1'b0;
      waddr = clr_ff;
      cnt_wdata = '0;
      qual_wdata = '0;
      raddr = {head_op.addr_x, head_op.addr_y};

      case (state_ff)
         cgr_pkg::BK_CLEAR: begin
            we = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = cgr_pkg::BK_IDLE;
            end
         end
         cgr_pkg::BK_IDLE: begin
            if (head_valid) begin
               pop = 1'b1;
               if (head_op.kind == cgr_pkg::OP_NONE) begin
                  rsp_valid_in = 1'b1;
                  rsp_in.total_words = 32'(total_ff);
               end else begin
                  op_in = head_op;
                  state_in = cgr_pkg::BK_WAIT;
               end
            end
         end
         cgr_pkg::BK_WAIT: begin
            rsp_valid_in = 1'b1;
            rsp_in.cell_x = 8'(op_ff.addr_x);
            rsp_in.cell_y = 8'(op_ff.addr_y);
            if (op_ff.kind == cgr_pkg::OP_UPDATE) begin
               cnt_wdata = cnt_rdata + 1'b1;
               qual_wdata = qual_rdata + op_ff.excess;
               we = 1'b1;
               waddr = {op_ff.addr_x, op_ff.addr_y};
               total_in = total_ff + 1'b1;
               rsp_in.word_done = 1'b1;
               rsp_in.cell_count = 32'(cnt_wdata);
               rsp_in.cell_quality = 32'(qual_wdata);
               rsp_in.total_words = 32'(total_in);
            end else begin
               rsp_in.cell_count = 32'(cnt_rdata);
               rsp_in.cell_quality = 32'(qual_rdata);
               rsp_in.total_words = 32'(total_ff);
            end
            state_in = cgr_pkg::BK_IDLE;
         end
         default: begin
            state_in = cgr_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cgr_pkg::BK_CLEAR;
         clr_ff <= '0;
         total_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         total_ff <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff <= op_in;
      rsp_ff <= rsp_in;
   end

   assign clearing = (state_ff == cgr_pkg::BK_CLEAR);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

[rtl/cgr_checker.sv]
// Port-level checks of the k-mer histogram core, bound to its top level.
// Depends on cgr_pkg and cgr_kmer_histogram_core.
module cgr_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic                 rsp_valid,
   input cgr_pkg::cgr_rsp_type rsp_data
);

   logic [3:0]  pending_ff, pending_in;
   logic [31:0] last_total_ff, last_total_in;
   logic [31:0] next_total;

   always_comb begin
      pending_in = pending_ff;
      if ((start && !busy) && !rsp_valid) begin
         pending_in = pending_ff + 1'b1;
      end else if (!(start && !busy) && rsp_valid) begin
         pending_in = pending_ff - 1'b1;
      end
      last_total_in = rsp_valid ? rsp_data.total_words : last_total_ff;
      next_total = last_total_ff + 32'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         last_total_ff <= '0;
      end else begin
         pending_ff <= pending_in;
         last_total_ff <= last_total_in;
      end
   end

   a_clear_after_reset: assert property (@(posedge clock) $past(reset) && !reset |-> busy)
      else $error("Block accepted work right after reset instead of clearing its tables.");

   a_no_spurious_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 4'd0)
      else $error("Result delivered without an outstanding transaction.");

   a_total_steps_on_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.word_done |-> rsp_data.total_words == next_total)
      else $error("Total word count did not advance by one on a completed word.");

   a_total_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.word_done |-> rsp_data.total_words == last_total_ff)
      else $error("Total word count changed on a result without a completed word.");

endmodule

bind cgr_kmer_histogram_core cgr_checker u_checker (.*);

[tb/sv/cgr_kmer_histogram_core_checker.sv]
// Checker for the chaos-game k-mer histogram core: watches the request, result and
// register write channels, predicts every result and compares it with the one observed.
// Depends on cgr_pkg.
module cgr_kmer_histogram_core_checker
   import cgr_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       busy,
   input  cgr_req_type                req_data,
   input  logic                       rsp_valid,
   input  cgr_rsp_type                rsp_data,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data,
   output int                         mismatches,
   output int                         outstanding
);

   logic [3:0]  kmer_len;
   logic [7:0]  qual_offset;
   logic        only_valid;
   coord_type   x_bits;
   coord_type   y_bits;
   int unsigned run_length;
   int unsigned window_sum;
   logic [7:0]  qual_window [MAX_K];
   count_type   count_table [TABLE_DEPTH];
   count_type   quality_table [TABLE_DEPTH];
   count_type   word_total;
   cgr_rsp_type pending_cells [$];
   int          error_count;

   function automatic int unsigned active_k();
      if (kmer_len == 4'd0) return 1;
      if (kmer_len > MAX_K) return MAX_K;
      return 32'(kmer_len);
   endfunction

   function automatic cgr_rsp_type count_kmer(cgr_req_type item);
      cgr_rsp_type res;
      int unsigned k;
      int          i;
      logic        is_base;
      logic        bx;
      logic        by;
      coord_type   cx;
      coord_type   cy;
      addr_type    cell_idx;
      res = '0;
      k = active_k();
      is_base = 1'b0;
      bx = 1'b0;
      by = 1'b0;
      if (item.cmd == CMD_READ) begin
         cell_idx = {item.addr_x, item.addr_y};
         res.cell_x = item.addr_x;
         res.cell_y = item.addr_y;
         res.cell_count = count_table[cell_idx];
         res.cell_quality = quality_table[cell_idx];
         res.total_words = word_total;
         return res;
      end
      if (!(only_valid && !item.read_valid)) begin
         case (item.base_char)
            CHAR_A: begin
               is_base = 1'b1;
               bx = 1'b1;
               by = 1'b0;
            end
            CHAR_C: begin
               is_base = 1'b1;
               bx = 1'b0;
               by = 1'b0;
            end
            CHAR_G: begin
               is_base = 1'b1;
               bx = 1'b0;
               by = 1'b1;
            end
            CHAR_T: begin
               is_base = 1'b1;
               bx = 1'b1;
               by = 1'b1;
            end
            CHAR_N: begin
               run_length = 0;
               window_sum = 0;
            end
            default: ;
         endcase
      end
      if (is_base) begin
         x_bits = {bx, x_bits[MAX_K-1:1]};
         y_bits = {by, y_bits[MAX_K-1:1]};
         for (i = MAX_K - 1; i > 0; i--) qual_window[i] = qual_window[i-1];
         qual_window[0] = item.quality_char;
         window_sum = window_sum + item.quality_char;
         run_length++;
         if (run_length >= k) begin
            cx = x_bits >> (MAX_K - k);
            cy = y_bits >> (MAX_K - k);
            cell_idx = {cx, cy};
            count_table[cell_idx] = count_table[cell_idx] + 1;
            quality_table[cell_idx] = quality_table[cell_idx] + window_sum - qual_offset * k;
            word_total = word_total + 1;
            window_sum = window_sum - qual_window[WIN_IDX_WIDTH'(k - 1)];
            run_length = k - 1;
            res.word_done = 1'b1;
            res.cell_x = cx;
            res.cell_y = cy;
            res.cell_count = count_table[cell_idx];
            res.cell_quality = quality_table[cell_idx];
         end
      end
      if (item.read_end) begin
         run_length = 0;
         window_sum = 0;
      end
      res.total_words = word_total;
      return res;
   endfunction

   always @(posedge clock) begin
      cgr_rsp_type want;
      if (reset) begin
         kmer_len = KMER_LEN_RESET;
         qual_offset = QUAL_OFFSET_RESET;
         only_valid = 1'b0;
         x_bits = '0;
         y_bits = '0;
         run_length = 0;
         window_sum = 0;
         word_total = '0;
         foreach (qual_window[i]) qual_window[i] = '0;
         foreach (count_table[i]) count_table[i] = '0;
         foreach (quality_table[i]) quality_table[i] = '0;
         pending_cells.delete();
         error_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_KMER_LEN: begin
                  kmer_len = csr_data[3:0];
                  run_length = 0;
                  window_sum = 0;
               end
               REG_QUAL_OFFSET: qual_offset = csr_data[7:0];
               REG_ONLY_VALID: only_valid = csr_data[0];
               default: ;
            endcase
         end
         if (start && !busy) pending_cells.push_back(count_kmer(req_data));
         if (rsp_valid) begin
            if (pending_cells.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("Result with no transaction pending: x=%0d y=%0d count=%0d",
                           rsp_data.cell_x, rsp_data.cell_y, rsp_data.cell_count);
            end else begin
               want = pending_cells.pop_front();
               if (rsp_data.word_done !== want.word_done || rsp_data.cell_x !== want.cell_x
                   || rsp_data.cell_y !== want.cell_y || rsp_data.cell_count !== want.cell_count
                   || rsp_data.cell_quality !== want.cell_quality
                   || rsp_data.total_words !== want.total_words) begin
                  error_count++;
                  if (error_count <= 10) begin
                     $display("Mismatch: expected done=%0d x=%0d y=%0d count=%0d qual=%0d total=%0d",
                              want.word_done, want.cell_x, want.cell_y, want.cell_count,
                              want.cell_quality, want.total_words);
                     $display("          actual   done=%0d x=%0d y=%0d count=%0d qual=%0d total=%0d",
                              rsp_data.word_done, rsp_data.cell_x, rsp_data.cell_y,
                              rsp_data.cell_count, rsp_data.cell_quality, rsp_data.total_words);
                  end
               end
            end
         end
      end
      mismatches <= error_count;
      outstanding <= pending_cells.size();
   end

endmodule

[tb/sv/cgr_kmer_histogram_core_tb.sv]
// Top of the k-mer histogram core testbench: clock, reset, directed and random base
// streams, cell reads and register writes, and the final verdict.
// Depends on cgr_pkg, cgr_kmer_histogram_core and cgr_kmer_histogram_core_checker.
module cgr_kmer_histogram_core_tb;
   import cgr_pkg::*;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SPARE = 2'd3;
   localparam logic [7:0] CHAR_LOWER_A = 8'd97;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   cgr_req_type                req_data = '0;
   logic                       rsp_valid;
   cgr_rsp_type                rsp_data;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_data = '0;
   int                         mismatches;
   int                         outstanding;

   int unsigned cur_k = 4;
   int unsigned bases_left = 0;
   logic        read_passed = 1'b1;
   logic [7:0]  nucleotides [4] = '{CHAR_A, CHAR_C, CHAR_G, CHAR_T};

   cgr_kmer_histogram_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   cgr_kmer_histogram_core_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #(12 * 1000000);
      $display("cgr_kmer_histogram_core test failed");
      $finish;
   end

   function automatic cgr_req_type base_item(logic [7:0] ch, logic [7:0] q, logic ok,
                                             logic last);
      cgr_req_type item;
      item.cmd = CMD_FEED;
      item.base_char = ch;
      item.quality_char = q;
      item.read_valid = ok;
      item.read_end = last;
      item.addr_x = 8'($urandom_range(0, 255));
      item.addr_y = 8'($urandom_range(0, 255));
      return item;
   endfunction

   function automatic cgr_req_type read_item(logic [7:0] ax, logic [7:0] ay);
      cgr_req_type item;
      item.cmd = CMD_READ;
      item.base_char = 8'($urandom_range(0, 255));
      item.quality_char = 8'($urandom_range(0, 255));
      item.read_valid = 1'($urandom_range(0, 1));
      item.read_end = 1'($urandom_range(0, 1));
      item.addr_x = ax;
      item.addr_y = ay;
      return item;
   endfunction

   // Mostly well-formed reads of A, C, G and T; some N, stray bytes, failed reads and cell reads.
   function automatic cgr_req_type random_item();
      int unsigned pick;
      int unsigned side;
      logic [7:0]  ch;
      logic [7:0]  q;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         side = (1 << cur_k) - 1;
         if ($urandom_range(0, 9) < 7)
            return read_item(8'($urandom_range(0, side)), 8'($urandom_range(0, side)));
         return read_item(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end
      if (bases_left == 0) begin
         bases_left = ($urandom_range(0, 9) == 0) ? $urandom_range(31, 120)
                                                   : $urandom_range(1, 30);
         read_passed = ($urandom_range(0, 7) != 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 88) ch = nucleotides[2'($urandom_range(0, 3))];
      else if (pick < 93) ch = CHAR_N;
      else ch = 8'($urandom_range(0, 255));
      q = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                      : 8'($urandom_range(33, 74));
      bases_left--;
      return base_item(ch, q, read_passed, bases_left == 0);
   endfunction

   task automatic issue(cgr_req_type item);
      req_data <= item;
      start <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   task automatic wait_drain();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_reg(logic [CSR_INDEX_WIDTH-1:0] idx, logic [CSR_DATA_WIDTH-1:0] val);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic configure(logic [3:0] ws, logic [7:0] bq, logic ov);
      logic [3:0] upper;
      logic [6:0] spare;
      upper = 4'($urandom_range(0, 15));
      spare = 7'($urandom_range(0, 127));
      wait_drain();
      write_reg(REG_KMER_LEN, {upper, ws});
      write_reg(REG_QUAL_OFFSET, bq);
      write_reg(REG_ONLY_VALID, {spare, ov});
      write_reg(REG_SPARE, 8'($urandom_range(0, 255)));
      csr_valid <= 1'b0;
      cur_k = (ws == 4'd0) ? 1 : ((ws > MAX_K) ? MAX_K : 32'(ws));
      bases_left = 0;
   endtask

   task automatic run_phase(logic [3:0] ws, logic [7:0] bq, logic ov, int n_items, bit idle,
                            bit mid_drain);
      bit gappy;
      int i;
      gappy = 1'b0;
      configure(ws, bq, ov);
      for (i = 0; i < n_items; i++) begin
         if (i % 40 == 0) gappy = idle && ($urandom_range(0, 2) != 0);
         if (mid_drain && i == n_items / 2) wait_drain();
         issue(random_item());
         if (gappy && $urandom_range(0, 4) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      issue(base_item(CHAR_A, 8'd0, 1'b1, 1'b0));
      issue(base_item(CHAR_C, 8'd255, 1'b1, 1'b0));
      issue(base_item(CHAR_G, 8'd40, 1'b1, 1'b0));
      issue(base_item(CHAR_T, 8'd50, 1'b1, 1'b0));
      issue(base_item(CHAR_A, 8'd60, 1'b1, 1'b0));
      issue(read_item(8'd12, 8'd6));
      issue(read_item(8'd255, 8'd255));
      issue(read_item(8'd0, 8'd0));
      issue(base_item(CHAR_N, 8'd70, 1'b1, 1'b0));
      issue(base_item(CHAR_LOWER_A, 8'd80, 1'b1, 1'b0));
      issue(base_item(8'h00, 8'd90, 1'b1, 1'b0));
      issue(base_item(8'hFF, 8'd255, 1'b1, 1'b0));
      issue(base_item(CHAR_G, 8'd33, 1'b0, 1'b0));
      issue(base_item(CHAR_G, 8'd34, 1'b0, 1'b0));
      issue(base_item(CHAR_G, 8'd35, 1'b0, 1'b0));
      issue(base_item(CHAR_G, 8'd36, 1'b0, 1'b1));
      issue(base_item(CHAR_T, 8'd37, 1'b1, 1'b1));
      issue(read_item(8'd9, 8'd12));

      configure(4'd0, 8'd255, 1'b1);
      issue(base_item(CHAR_A, 8'd100, 1'b0, 1'b0));
      issue(base_item(CHAR_C, 8'd0, 1'b1, 1'b0));
      issue(base_item(CHAR_T, 8'd255, 1'b1, 1'b0));
      issue(base_item(CHAR_G, 8'd20, 1'b0, 1'b1));
      issue(read_item(8'd0, 8'd0));

      run_phase(4'd8, 8'd0, 1'b0, 250, 1'b1, 1'b0);
      run_phase(4'd2, 8'd255, 1'b1, 250, 1'b1, 1'b1);
      run_phase(4'd9, 8'd33, 1'b0, 250, 1'b1, 1'b0);
      run_phase(4'd15, 8'd0, 1'b1, 250, 1'b1, 1'b0);
      run_phase(4'd1, 8'd200, 1'b0, 250, 1'b1, 1'b0);
      run_phase(4'd3, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 250, 1'b1, 1'b0);
      run_phase(4'd6, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 250, 1'b1, 1'b0);
      run_phase(4'd4, 8'd33, 1'b0, 250, 1'b0, 1'b0);

      wait_drain();
      repeat (16) @(posedge clock);
      if (mismatches == 0) begin
         $display("cgr_kmer_histogram_core test passed");
      end else begin
         $display("cgr_kmer_histogram_core test failed");
      end
      $finish;
   end

endmodule
